FILE: sv/ltm_pkg.sv
// Shared constants, tables and types for the map tile index pipeline.
// Used by every module of the block; depends on nothing.
package ltm_pkg;

  localparam int TILE_W    = 18;
  localparam int LAT_W     = 31;
  localparam int LON_W     = 32;
  localparam int ZOOM_W    = 5;

  localparam int MAX_ZOOM_DEF = 18;
  localparam int FRAC_DEF     = 23;

  localparam int CIRC_ITERS = 30;
  localparam int HYP_STEPS  = 32;
  localparam int NORM_STEPS = 5;
  localparam int DIV_LAT    = 4;

  localparam int CORD_W = 34;
  localparam int LN_W   = 38;

  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
  localparam logic [31:0] CIRC_K0    = 32'd652032874;
  localparam logic [26:0] DEG2RAD    = 27'd74961321;
  localparam logic [32:0] PI_Q30     = 33'd3373259426;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [29:0] LN2_Q30    = 30'd744261118;

  localparam int          COL_K      = 32;
  localparam logic [26:0] COL_RECIP  = 27'd95443717;
  localparam int          COL_DIV    = 45;

  localparam int          ROW_K      = 58;
  localparam logic [63:0] ROW_RECIP_64 = (64'd1 << ROW_K) / 64'd6746518852;
  localparam logic [25:0] ROW_RECIP  = ROW_RECIP_64[25:0];

  localparam logic [31:0] CIRC_TAB [10] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543515,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149
  };

  localparam logic [31:0] HYP_TAB [10] = '{
    32'd0,        32'd589812981, 32'd274247419, 32'd134923407, 32'd67196452,
    32'd33565361, 32'd16778581,  32'd8388779,   32'd4194325,   32'd2097155
  };

  typedef struct packed {
    logic [30:0] sn;
    logic [30:0] cs;
    logic        pole;
  } circ_res_t;

  function automatic logic [31:0] circ_angle(input int i);
    if (i < 10) return CIRC_TAB[i];
    return 32'd1 << (30 - i);
  endfunction

  function automatic logic [31:0] hyp_angle(input int i);
    if (i < 10) return HYP_TAB[i];
    return 32'd1 << (30 - i);
  endfunction

  // shifts 4 and 13 run twice
  function automatic int hyp_shift(input int s);
    if (s < 4) return s + 1;
    if (s < 14) return s;
    return s - 1;
  endfunction

endpackage

FILE: sv/ltm_circ_cordic.sv
// Pipelined circular CORDIC, one rotation per stage, then sin/cos clamp.
// Depends on ltm_pkg.
module ltm_circ_cordic (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [31:0]          theta_i,
  output ltm_pkg::circ_res_t   res_o
);

  localparam int CW = ltm_pkg::CORD_W;
  localparam int N  = ltm_pkg::CIRC_ITERS;
  localparam logic signed [CW-1:0] ONE_S = $signed(CW'(ltm_pkg::ONE_Q30));

  logic signed [CW-1:0] x_q [N];
  logic signed [CW-1:0] y_q [N];
  logic signed [CW-1:0] z_q [N];

  for (genvar g = 0; g < N; g++) begin : g_iter
    localparam logic signed [CW-1:0] ANG = $signed(CW'(ltm_pkg::circ_angle(g)));
    logic signed [CW-1:0] xi, yi, zi;
    if (g == 0) begin : g_first
      assign xi = $signed(CW'(ltm_pkg::CIRC_K0));
      assign yi = '0;
      assign zi = $signed(CW'(theta_i));
    end else begin : g_next
      assign xi = x_q[g-1];
      assign yi = y_q[g-1];
      assign zi = z_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zi[CW-1]) begin
          x_q[g] <= xi - (yi >>> g);
          y_q[g] <= yi + (xi >>> g);
          z_q[g] <= zi - ANG;
        end else begin
          x_q[g] <= xi + (yi >>> g);
          y_q[g] <= yi - (xi >>> g);
          z_q[g] <= zi + ANG;
        end
      end
    end
  end

  logic signed [CW-1:0] sn_c, cs_c;

  always_comb begin
    sn_c = y_q[N-1];
    if (sn_c[CW-1]) sn_c = '0;
    else if (sn_c > ONE_S) sn_c = ONE_S;
    cs_c = x_q[N-1];
    if (cs_c > ONE_S) cs_c = ONE_S;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.sn   <= sn_c[30:0];
      res_o.cs   <= cs_c[30:0];
      res_o.pole <= cs_c[CW-1] || (cs_c == '0);
    end
  end

endmodule

FILE: sv/ltm_ln_unit.sv
// Pipelined natural log in Q30: normalize, hyperbolic CORDIC, add k*ln2.
// Depends on ltm_pkg.
module ltm_ln_unit (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [31:0]                        v_i,
  output logic signed [ltm_pkg::LN_W-1:0]    ln_o
);

  localparam int CW = ltm_pkg::CORD_W;
  localparam int NN = ltm_pkg::NORM_STEPS;
  localparam int NH = ltm_pkg::HYP_STEPS;
  localparam int LW = ltm_pkg::LN_W;
  localparam logic signed [CW-1:0] ONE_S = $signed(CW'(ltm_pkg::ONE_Q30));
  localparam logic signed [LW-1:0] LN2_S = $signed(LW'(ltm_pkg::LN2_Q30));

  logic        [30:0] m_q [NN];
  logic signed [5:0]  k_q [NN];

  for (genvar g = 0; g < NN; g++) begin : g_norm
    localparam int SH = 16 >> g;
    logic        [30:0] mi, m_d;
    logic signed [5:0]  ki, k_d;
    logic               top;
    if (g == 0) begin : g_first
      assign mi  = v_i[30:0];
      assign ki  = '0;
      assign top = v_i[31];
    end else begin : g_next
      assign mi  = m_q[g-1];
      assign ki  = k_q[g-1];
      assign top = 1'b0;
    end
    always_comb begin
      m_d = mi;
      k_d = ki;
      if (top) begin
        m_d = v_i[31:1];
        k_d = 6'sd1;
      end else if (mi[30 -: SH] == '0) begin
        m_d = mi << SH;
        k_d = ki - $signed(6'(SH));
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[g] <= m_d;
        k_q[g] <= k_d;
      end
    end
  end

  logic signed [CW-1:0] x_q  [NH];
  logic signed [CW-1:0] y_q  [NH];
  logic signed [CW-1:0] z_q  [NH];
  logic signed [5:0]    kh_q [NH];

  for (genvar g = 0; g < NH; g++) begin : g_hyp
    localparam int SH = ltm_pkg::hyp_shift(g);
    localparam logic signed [CW-1:0] ANG = $signed(CW'(ltm_pkg::hyp_angle(SH)));
    logic signed [CW-1:0] xi, yi, zi;
    logic signed [5:0]    ki;
    if (g == 0) begin : g_first
      assign xi = $signed(CW'(m_q[NN-1])) + ONE_S;
      assign yi = $signed(CW'(m_q[NN-1])) - ONE_S;
      assign zi = '0;
      assign ki = k_q[NN-1];
    end else begin : g_next
      assign xi = x_q[g-1];
      assign yi = y_q[g-1];
      assign zi = z_q[g-1];
      assign ki = kh_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        kh_q[g] <= ki;
        if (!yi[CW-1]) begin
          x_q[g] <= xi - (yi >>> SH);
          y_q[g] <= yi - (xi >>> SH);
          z_q[g] <= zi + ANG;
        end else begin
          x_q[g] <= xi + (yi >>> SH);
          y_q[g] <= yi + (xi >>> SH);
          z_q[g] <= zi - ANG;
        end
      end
    end
  end

  logic signed [LW-1:0] z_ext, k_ext;
  assign z_ext = LW'(z_q[NH-1]);
  assign k_ext = LW'(kh_q[NH-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) ln_o <= (z_ext <<< 1) + k_ext * LN2_S;
  end

endmodule

FILE: sv/ltm_row_div.sv
// Row index: floor(num * 2^zoom / 2pi) by reciprocal multiply and one correction.
// Depends on ltm_pkg.
module ltm_row_div #(
  parameter int MAX_ZOOM = ltm_pkg::MAX_ZOOM_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [32:0]          num_i,
  input  logic [4:0]           zc_i,
  output logic [MAX_ZOOM-1:0]  row_o
);

  localparam int ZW = MAX_ZOOM;
  localparam int PW = 33 + 26;
  localparam int TW = 33 + ZW;
  localparam int QW = ZW + 34;

  logic [PW-1:0] prod_q;
  logic [32:0]   num_q;
  logic [4:0]    zc_q;
  logic [ZW-1:0] est_q, est2_q;
  logic [TW-1:0] tgt_q, tgt2_q;
  logic [QW-1:0] p2_q;
  logic [5:0]    sh;

  assign sh = 6'(ltm_pkg::ROW_K) - 6'(zc_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(num_i) * PW'(ltm_pkg::ROW_RECIP);
      num_q  <= num_i;
      zc_q   <= zc_i;
      est_q  <= ZW'(prod_q >> sh);
      tgt_q  <= TW'(num_q) << zc_q;
      p2_q   <= ((QW'(est_q) + QW'(1)) * QW'(ltm_pkg::TWO_PI_Q30));
      est2_q <= est_q;
      tgt2_q <= tgt_q;
      row_o  <= (p2_q <= QW'(tgt2_q)) ? est2_q + ZW'(1) : est2_q;
    end
  end

endmodule

FILE: sv/latlon_to_map_tile.sv
// Top level: lat/lon/zoom to Web Mercator tile column, row and flipped row.
// Depends on ltm_pkg, ltm_circ_cordic, ltm_ln_unit and ltm_row_div.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o | latitude_i, longitude_i, zoom_i
//   out     | out_valid_o/out_ready_i | tile_column_o, tile_row_o, flipped_row_o,
//           |                         | out_of_range_o
//
// One item per cycle while the output is not stalled; the pipe depth is set by the 30-stage
// sin/cos CORDIC and the 38-stage log units behind it.
// Reset clears the sideband line and out_valid_o only; the datapath is not reset and no clearing pass runs.
// A held result stalls the pipe only when its last stage is full; bubbles drain.
module latlon_to_map_tile #(
  parameter int MAX_ZOOM        = ltm_pkg::MAX_ZOOM_DEF,
  parameter int ANGLE_FRAC_BITS = ltm_pkg::FRAC_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [ltm_pkg::LAT_W-1:0]  latitude_i,
  input  logic signed [ltm_pkg::LON_W-1:0]  longitude_i,
  input  logic [ltm_pkg::ZOOM_W-1:0]        zoom_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ltm_pkg::TILE_W-1:0]        tile_column_o,
  output logic [ltm_pkg::TILE_W-1:0]        tile_row_o,
  output logic [ltm_pkg::TILE_W-1:0]        flipped_row_o,
  output logic                              out_of_range_o
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int ZW    = MAX_ZOOM;
  localparam int TW    = ltm_pkg::TILE_W;
  localparam int LW    = ltm_pkg::LN_W;
  localparam int MW    = LW + 2;
  localparam int POS_W = ((F + 9 > 32) ? F + 9 : 32) + 1;
  localparam int CMP_W = (F + 7 > 31) ? F + 8 : 32;
  localparam int TP_W  = F + 34;
  localparam int QW    = ZW + 6;
  localparam int PQW   = QW + 27;

  localparam int IX_COLF = 1;
  localparam int IX_COL  = 3;
  localparam int IX_CIRC = 1 + ltm_pkg::CIRC_ITERS + 1;
  localparam int IX_POLE = IX_CIRC + 1;
  localparam int IX_LN   = IX_CIRC + ltm_pkg::NORM_STEPS + ltm_pkg::HYP_STEPS + 1;
  localparam int IX_MERC = IX_LN + 1;
  localparam int IX_NUM  = IX_MERC + 1;
  localparam int IX_ROW  = IX_NUM + ltm_pkg::DIV_LAT;
  localparam int NS      = IX_ROW + 1;

  localparam logic signed [POS_W-1:0] HALF = $signed(POS_W'(180) << F);
  localparam logic signed [POS_W-1:0] SPAN = $signed(POS_W'(360) << F);
  localparam logic [CMP_W-1:0]        LIM  = CMP_W'(90) << F;
  localparam logic signed [MW-1:0]    PI_S = $signed(MW'(ltm_pkg::PI_Q30));
  localparam logic signed [MW-1:0]    TPI_S = $signed(MW'(ltm_pkg::TWO_PI_Q30));

  typedef struct packed {
    logic          valid;
    logic [4:0]    zc;
    logic          lat_neg;
    logic          lat_zero;
    logic          lat_pole;
    logic          pole;
    logic          col_lo;
    logic          col_hi;
    logic [ZW-1:0] col;
    logic          row_sat;
    logic          row_hi;
  } side_t;

  side_t side_q [NS];
  side_t side_d [NS];

  logic en, load_out;

  assign load_out   = out_ready_i || !out_valid_o;
  assign en         = load_out || !side_q[IX_ROW].valid;
  assign in_ready_o = en;

  function automatic logic [ZW-1:0] tiles_m1(input logic [4:0] zc);
    return ~({ZW{1'b1}} << zc);
  endfunction

  // input stage
  logic [4:0]              zc_in;
  logic signed [30:0]      lat_abs;
  logic [30:0]             a_q;
  logic signed [POS_W-1:0] pos_q;

  assign zc_in   = (zoom_i > 5'(MAX_ZOOM)) ? 5'(MAX_ZOOM) : zoom_i;
  assign lat_abs = latitude_i[30] ? -latitude_i : latitude_i;

  // column path
  logic [POS_W-2+ZW:0] pos_sh;
  logic [QW-1:0]       q_q, q3_q;
  logic [PQW-1:0]      p45_q;
  logic [ZW-1:0]       col_est;
  logic [ZW+6:0]       col_chk;
  logic [ZW-1:0]       col_d;
  logic [TP_W-1:0]     th_prod;
  logic [31:0]         theta_q;

  assign pos_sh  = (POS_W - 1 + ZW)'(pos_q[POS_W-2:0]) << side_q[0].zc;
  assign th_prod = TP_W'(a_q) * TP_W'(ltm_pkg::DEG2RAD);
  assign col_est = ZW'(p45_q >> ltm_pkg::COL_K);
  assign col_chk = ((ZW + 7)'(col_est) + (ZW + 7)'(1)) * (ZW + 7)'(ltm_pkg::COL_DIV);

  always_comb begin
    if (side_q[IX_COL-1].col_lo) col_d = '0;
    else if (side_q[IX_COL-1].col_hi) col_d = tiles_m1(side_q[IX_COL-1].zc);
    else if (col_chk <= (ZW + 7)'(q3_q)) col_d = col_est + ZW'(1);
    else col_d = col_est;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= lat_abs;
      pos_q   <= POS_W'(longitude_i) + HALF;
      theta_q <= 32'(th_prod >> (F + 2));
      q_q     <= QW'(pos_sh >> (F + 3));
      q3_q    <= q_q;
      p45_q   <= PQW'(q_q) * PQW'(ltm_pkg::COL_RECIP);
    end
  end

  // Mercator term
  ltm_pkg::circ_res_t circ_res;
  logic signed [LW-1:0] ln_num, ln_den;

  ltm_circ_cordic u_circ (
    .clk_i   (clk_i),
    .en_i    (en),
    .theta_i (theta_q),
    .res_o   (circ_res)
  );

  ltm_ln_unit u_ln_num (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   ({1'b0, circ_res.sn} + ltm_pkg::ONE_Q30),
    .ln_o  (ln_num)
  );

  ltm_ln_unit u_ln_den (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   ({1'b0, circ_res.cs}),
    .ln_o  (ln_den)
  );

  logic signed [MW-1:0] diff, merc_q, num_d, num_q;

  assign diff  = MW'(ln_num) - MW'(ln_den);
  assign num_d = PI_S - merc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side_q[IX_LN].lat_zero) merc_q <= '0;
      else if (side_q[IX_LN].lat_neg) merc_q <= -diff;
      else merc_q <= diff;
      num_q <= num_d;
    end
  end

  logic [ZW-1:0] row_div;

  ltm_row_div #(
    .MAX_ZOOM (MAX_ZOOM)
  ) u_row_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_q[32:0]),
    .zc_i  (side_q[IX_NUM].zc),
    .row_o (row_div)
  );

  // sideband line
  always_comb begin
    logic force_row, num_hi;
    side_d[0]          = '0;
    side_d[0].valid    = in_valid_i;
    side_d[0].zc       = zc_in;
    side_d[0].lat_neg  = latitude_i[30];
    side_d[0].lat_zero = (latitude_i == '0);
    side_d[0].lat_pole = (CMP_W'(lat_abs) >= LIM);
    for (int j = 1; j < NS; j++) side_d[j] = side_q[j-1];
    side_d[IX_COLF].col_lo = pos_q[POS_W-1];
    side_d[IX_COLF].col_hi = !pos_q[POS_W-1] && (pos_q >= SPAN);
    side_d[IX_COL].col     = col_d;
    side_d[IX_POLE].pole   = circ_res.pole && !side_q[IX_CIRC].lat_zero;
    force_row = side_q[IX_MERC].lat_pole || side_q[IX_MERC].pole;
    num_hi    = !num_d[MW-1] && (num_d >= TPI_S);
    side_d[IX_NUM].row_sat = force_row || num_d[MW-1] || num_hi;
    side_d[IX_NUM].row_hi  = force_row ? side_q[IX_MERC].lat_neg : num_hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NS; j++) side_q[j] <= '0;
    end else if (en) begin
      for (int j = 0; j < NS; j++) side_q[j] <= side_d[j];
    end
  end

  // output register
  logic [ZW-1:0] tm1, row_fin;

  assign tm1 = tiles_m1(side_q[IX_ROW].zc);

  always_comb begin
    if (side_q[IX_ROW].row_sat) row_fin = side_q[IX_ROW].row_hi ? tm1 : '0;
    else row_fin = row_div;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= side_q[IX_ROW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out && side_q[IX_ROW].valid) begin
      tile_column_o  <= TW'(side_q[IX_ROW].col);
      tile_row_o     <= TW'(row_fin);
      flipped_row_o  <= TW'(tm1 - row_fin);
      out_of_range_o <= side_q[IX_ROW].col_lo || side_q[IX_ROW].col_hi ||
                        side_q[IX_ROW].row_sat;
    end
  end

endmodule
